/* rtl/core/lbt_pkg.sv */
// ============================================================================
// lbt_pkg
// Shared types and constants for the live block tracker table.
// ============================================================================
`default_nettype none

package lbt_pkg;

    localparam int ADDR_W          = 48;
    localparam int SIZE_W          = 32;
    localparam int STATUS_W        = 2;
    localparam int LIVE_COUNT_W    = 10;
    localparam int BUSY_W          = 41;
    localparam int TABLE_DEPTH_DEF = 1024;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // One table slot as stored in the slot memory.
    typedef struct packed {
        logic              used;
        logic              tomb;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_slot;

endpackage

`default_nettype wire

/* rtl/core/lbt_slot_ram.sv */
// ============================================================================
// lbt_slot_ram
// Single-port-write, single-port-read slot memory with registered read data.
// ============================================================================
`default_nettype none

module lbt_slot_ram
    import lbt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_slot         i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_slot              o_rd_data
);

    t_slot r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lbt_home_hash.sv */
// ============================================================================
// lbt_home_hash
// Computes the home slot, block address modulo the table depth.
// ============================================================================
`default_nettype none

module lbt_home_hash
    import lbt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [ADDR_W-1:0] i_addr,
    output logic                   o_done,
    output logic [IDX_W-1:0]       o_home
);

    localparam bit IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);

    generate
        if (IS_POW2) begin : g_mask
            // A power-of-two depth takes the low address bits directly.
            logic             r_done;
            logic [IDX_W-1:0] r_home;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_home <= i_addr[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_home = r_home;
        end else begin : g_nibble
            // Long division by the depth, one address nibble per cycle, most
            // significant first. Each step subtracts the largest multiple of
            // the depth that fits, picked from fifteen parallel compares.
            localparam int NIBBLES = ADDR_W / 4;
            localparam int STEP_W  = $clog2(NIBBLES);
            localparam int TRIAL_W = IDX_W + 4;

            logic               r_run;
            logic               r_done;
            logic [STEP_W-1:0]  r_step;
            logic [ADDR_W-1:0]  r_shift;
            logic [IDX_W-1:0]   r_rem;
            logic [TRIAL_W-1:0] w_trial;
            logic [TRIAL_W-1:0] w_red;
            logic               w_last;

            assign w_trial = {r_rem, r_shift[ADDR_W-1 -: 4]};
            assign w_last  = (r_step == STEP_W'(NIBBLES - 1));

            always_comb begin
                w_red = w_trial;
                for (int j = 1; j < 16; j++) begin
                    if (w_trial >= TRIAL_W'(j * DEPTH)) begin
                        w_red = w_trial - TRIAL_W'(j * DEPTH);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b0;
                    r_step <= '0;
                end else begin
                    r_done <= r_run && !i_start && w_last;
                    if (i_start) begin
                        r_run  <= 1'b1;
                        r_step <= '0;
                    end else if (r_run) begin
                        r_step <= r_step + 1'b1;
                        if (w_last) begin
                            r_run <= 1'b0;
                        end
                    end
                end
                if (i_start) begin
                    r_shift <= i_addr;
                    r_rem   <= '0;
                end else if (r_run) begin
                    r_shift <= r_shift << 4;
                    r_rem   <= w_red[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_home = r_rem;
        end
    endgenerate

endmodule

`default_nettype wire

/* rtl/core/live_block_tracker_table.sv */
// ============================================================================
// live_block_tracker_table
// Open-addressing table of live memory blocks with linear probing.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command: insert a
//   block (address, size) or remove a block by address. Output channel
//   (o_out_valid / i_out_ready) returns one result per command: status,
//   freed size, live block count and busy bytes after the command.
//   Commands are handled one at a time. An insert at half load or above is
//   refused with status full and goes straight to S_FINISH. Otherwise a
//   command passes S_HASH and S_PROBE, one slot memory read per cycle,
//   before S_FINISH. For a depth that is not a power of two the home slot
//   comes from the nibble-wide remainder unit.
//   A new command is taken while the previous result still waits; if the
//   receiver stalls, the block holds the finished result and stops before
//   presenting the next one.
//   After reset a clearing pass writes every one of the TABLE_DEPTH slots
//   (1024 by default), during which o_in_ready stays low.
// ============================================================================
`default_nettype none

module live_block_tracker_table
    import lbt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_command,
    input  wire logic [ADDR_W-1:0]       i_block_address,
    input  wire logic [SIZE_W-1:0]       i_block_size,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [STATUS_W-1:0]          o_status,
    output logic [SIZE_W-1:0]            o_freed_size,
    output logic [LIVE_COUNT_W-1:0]      o_live_count,
    output logic [BUSY_W-1:0]            o_busy_bytes
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH / 2 + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH
    } t_state;

    t_state               r_state;
    logic [IDX_W-1:0]     r_clr_idx;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_probe;
    logic                 r_cmd;
    logic [ADDR_W-1:0]    r_addr;
    logic [SIZE_W-1:0]    r_size;
    logic [CNT_W-1:0]     r_live;
    logic [BUSY_W-1:0]    r_busy;
    t_status              r_res_status;
    logic [SIZE_W-1:0]    r_res_freed;

    logic                 w_accept;
    logic                 w_half;
    logic                 w_hash_done;
    logic [IDX_W-1:0]     w_home;
    logic [IDX_W-1:0]     w_next_idx;
    logic                 w_last;
    logic                 w_stop;
    logic                 w_found;
    t_status              w_status;
    logic [31:0]          w_live_ext;

    logic                 w_rd_en;
    logic [IDX_W-1:0]     w_rd_addr;
    logic                 w_wr_en;
    logic [IDX_W-1:0]     w_wr_addr;
    t_slot                w_wr_data;
    t_slot                w_rd_data;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_half     = (r_live >= CNT_W'(TABLE_DEPTH / 2));
    assign w_next_idx = (r_idx == IDX_W'(TABLE_DEPTH - 1)) ? '0 : r_idx + 1'b1;
    assign w_last     = (r_probe == IDX_W'(TABLE_DEPTH - 1));
    assign w_live_ext = 32'(r_live);

    lbt_home_hash #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && !(i_command == CMD_INSERT && w_half)),
        .i_addr  (i_block_address),
        .o_done  (w_hash_done),
        .o_home  (w_home)
    );

    lbt_slot_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Probe evaluation on the slot read in the previous cycle.
    always_comb begin
        w_stop    = 1'b0;
        w_found   = 1'b0;
        w_status  = ST_OK;
        w_rd_en   = 1'b0;
        w_rd_addr = w_home;
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx;
        w_wr_data = '0;
        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_idx;
            end
            S_HASH: begin
                w_rd_en   = w_hash_done;
                w_rd_addr = w_home;
            end
            S_PROBE: begin
                if (r_cmd == CMD_INSERT) begin
                    if (!w_rd_data.used || w_rd_data.tomb) begin
                        w_stop    = 1'b1;
                        w_found   = 1'b1;
                        w_wr_en   = 1'b1;
                        w_wr_data = '{used: 1'b1, tomb: 1'b0, addr: r_addr, size: r_size};
                    end else if (w_last) begin
                        w_stop   = 1'b1;
                        w_status = ST_FULL;
                    end
                end else begin
                    if (!w_rd_data.used) begin
                        w_stop   = 1'b1;
                        w_status = ST_NOT_FOUND;
                    end else if (!w_rd_data.tomb && w_rd_data.addr == r_addr) begin
                        w_stop    = 1'b1;
                        w_found   = 1'b1;
                        w_wr_en   = 1'b1;
                        w_wr_data = w_rd_data;
                        w_wr_data.tomb = 1'b1;
                    end else if (w_last) begin
                        w_stop   = 1'b1;
                        w_status = ST_NOT_FOUND;
                    end
                end
                w_rd_en   = !w_stop;
                w_rd_addr = w_next_idx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_live      <= '0;
            r_busy      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && r_state != S_FINISH) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == IDX_W'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd  <= i_command;
                        r_addr <= i_block_address;
                        r_size <= i_block_size;
                        if (i_command == CMD_INSERT && w_half) begin
                            r_res_status <= ST_FULL;
                            r_res_freed  <= '0;
                            r_state      <= S_FINISH;
                        end else begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_idx   <= w_home;
                        r_probe <= '0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (w_stop) begin
                        r_res_status <= w_status;
                        r_res_freed  <= (w_found && r_cmd == CMD_REMOVE) ?
                                        w_rd_data.size : '0;
                        if (w_found && r_cmd == CMD_INSERT) begin
                            r_live <= r_live + 1'b1;
                            r_busy <= r_busy + BUSY_W'(r_size);
                        end else if (w_found) begin
                            if (r_live != '0) begin
                                r_live <= r_live - 1'b1;
                            end
                            r_busy <= r_busy - BUSY_W'(w_rd_data.size);
                        end
                        r_state <= S_FINISH;
                    end else begin
                        r_idx   <= w_next_idx;
                        r_probe <= r_probe + 1'b1;
                    end
                end
                S_FINISH: begin
                    // Present the result once the output register is free.
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid  <= 1'b1;
                        o_status     <= r_res_status;
                        o_freed_size <= r_res_freed;
                        o_live_count <= w_live_ext[LIVE_COUNT_W-1:0];
                        o_busy_bytes <= r_busy;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
